// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the top level of the gradient descent block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication under an active-low reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/core/lrgd_pkg.sv -----
// Types, constants and saturation helpers of the gradient descent block.
package lrgd_pkg;

  localparam int unsigned DW  = 32;
  localparam int unsigned OPW = 33;
  localparam int unsigned PW  = 66;

  localparam logic [23:0]        LR_RESET   = 24'd16777;
  localparam logic [15:0]        ITER_RESET = 16'd2000;
  localparam logic signed [31:0] B0_RESET   = 32'sd6553600;
  localparam logic signed [31:0] M0_RESET   = 32'sd3276800;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_RUN   = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_LR   = 2'd0,
    CFG_ITER = 2'd1,
    CFG_B0   = 2'd2,
    CFG_M0   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic              ovf;
    logic signed [31:0] val;
  } sat32_t;

  typedef struct packed {
    logic              ovf;
    logic signed [63:0] val;
  } sat64_t;

  // Clamp a 64 bit value to the signed 32 bit range
  function automatic sat32_t sat32(input logic signed [63:0] v);
    sat32_t r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r.ovf = 1'b1;
      r.val = 32'sh7FFF_FFFF;
    end else if (v < 64'shFFFF_FFFF_8000_0000) begin
      r.ovf = 1'b1;
      r.val = 32'sh8000_0000;
    end else begin
      r.ovf = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

  // Add two signed 64 bit values, clamped to the signed 64 bit range
  function automatic sat64_t sat_add64(input logic signed [63:0] a,
                                       input logic signed [63:0] b);
    logic [64:0] s;
    sat64_t      r;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      r.ovf = 1'b1;
      r.val = s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    end else begin
      r.ovf = 1'b0;
      r.val = s[63:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/lrgd_mul.sv -----
// Shared signed multiplier with a registered product.
module lrgd_mul (
  input  logic                            clk_i,
  input  logic signed [lrgd_pkg::OPW-1:0] a_i,
  input  logic signed [lrgd_pkg::OPW-1:0] b_i,
  output logic signed [lrgd_pkg::PW-1:0]  prod_o
);
  import lrgd_pkg::*;

  logic signed [PW-1:0] prod_q;

  // Register every product
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

// ----- rtl/core/lrgd_store.sv -----
// Point store: one (x, y) pair per entry, single port, registered read.
module lrgd_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic                       re_i,
  input  logic [AW-1:0]              addr_i,
  input  logic [2*lrgd_pkg::DW-1:0]  wdata_i,
  output logic [2*lrgd_pkg::DW-1:0]  rdata_o
);
  import lrgd_pkg::*;

  logic [2*DW-1:0] mem [DEPTH];
  logic [2*DW-1:0] rdata_q;

  // Write on load, read when the sequencer fetches a point
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/linear_regression_gradient_descent_top.sv -----
// Top level of the gradient descent line fit: sequencer, datapath and config registers.
//
// Usage:
//   Command channel: drive cmd_i, x_i, y_i and raise start; the transaction is
//   taken at a rising edge with start high and busy low. Clear and load never raise
//   busy, so loads may arrive back to back.
//   A run raises busy, performs I iterations over the N stored points and then
//   pulses done_o for one cycle with intercept_o, slope_o, points_used_o and
//   saturated_o valid. busy is low again in the done_o cycle.
//   Each point passes through ST_PCHK, ST_PMUL1, ST_PRES, ST_PMUL2 and ST_PACC:
//   one point store read and two passes through the shared 33x33 multiplier;
//   each iteration then updates both parameters, each update using the multiplier twice.
//   Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
//   ready is high while the block is idle.
//   Reset clears the point count, the saturation flag and the sequencer and
//   loads the default config. The receiver has no stall: the result ports
//   hold their values after the done_o cycle until a later command changes them.
`include "assert_macros.svh"

module linear_regression_gradient_descent_top #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd_i,
  input  logic signed [31:0] x_i,
  input  logic signed [31:0] y_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output logic               done_o,
  output logic signed [31:0] intercept_o,
  output logic signed [31:0] slope_o,
  output logic [10:0]        points_used_o,
  output logic               saturated_o
);
  import lrgd_pkg::*;

  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ITER, ST_PCHK, ST_PMUL1, ST_PRES, ST_PMUL2, ST_PACC,
    ST_SHI, ST_SLO, ST_STEP, ST_UPD
  } state_e;

  state_e             state_q;
  logic [23:0]        lr_q;
  logic [15:0]        iter_cfg_q;
  logic signed [31:0] b0_q;
  logic signed [31:0] m0_q;
  logic [CW-1:0]      cnt_q;
  logic [CW-1:0]      idx_q;
  logic [15:0]        iter_q;
  logic               ovf_q;
  logic               done_q;
  logic               sel_q;
  logic signed [31:0] b_q;
  logic signed [31:0] m_q;
  logic signed [31:0] r_q;
  logic signed [31:0] step_q;
  logic signed [63:0] sum_b_q;
  logic signed [63:0] sum_m_q;
  logic [55:0]        hi_q;

  logic               accept;
  logic               full;
  logic               mem_we;
  logic               mem_re;
  logic [AW-1:0]      mem_addr;
  logic [2*DW-1:0]    mem_rdata;
  logic signed [31:0] rd_x;
  logic signed [31:0] rd_y;
  logic signed [OPW-1:0] mul_a;
  logic signed [OPW-1:0] mul_b;
  logic signed [PW-1:0]  prod;

  logic signed [63:0] pred_w;
  logic signed [63:0] diff_w;
  logic signed [63:0] g1_w;
  logic signed [63:0] g2_w;
  logic signed [63:0] sum_sel;
  logic               neg;
  logic [63:0]        mag;
  logic [48:0]        t_w;
  logic [40:0]        q_w;
  logic signed [63:0] par_w;
  sat32_t             r_sat;
  sat32_t             step_sat;
  sat32_t             upd_sat;
  sat64_t             acc_b;
  sat64_t             acc_m;

  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = !busy;
  assign full        = (cnt_q == CW'(MAX_POINTS));

  // Point store: loads write at the fill count, the sequencer reads at its index
  assign mem_we   = accept && (cmd_e'(cmd_i) == CMD_LOAD) && !full;
  assign mem_re   = (state_q == ST_PCHK) && (idx_q != cnt_q);
  assign mem_addr = busy ? idx_q[AW-1:0] : cnt_q[AW-1:0];

  lrgd_store #(
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i ({x_i, y_i}),
    .rdata_o (mem_rdata)
  );

  assign rd_x = mem_rdata[2*DW-1:DW];
  assign rd_y = mem_rdata[DW-1:0];

  // Magnitude of the gradient sum being scaled
  always_comb begin
    sum_sel = sel_q ? sum_m_q : sum_b_q;
    neg     = sum_sel[63];
    mag     = neg ? (~sum_sel + 64'd1) : sum_sel;
  end

  // Select multiplier operands by sequencer step
  always_comb begin
    unique case (state_q)
      ST_PMUL1: begin
        mul_a = OPW'(m_q);
        mul_b = OPW'(rd_x);
      end
      ST_PMUL2: begin
        mul_a = OPW'(r_q);
        mul_b = OPW'(rd_x);
      end
      ST_SHI: begin
        mul_a = {1'b0, mag[63:32]};
        mul_b = {9'b0, lr_q};
      end
      ST_SLO: begin
        mul_a = {1'b0, mag[31:0]};
        mul_b = {9'b0, lr_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  lrgd_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Residual, gradient terms and running sums
  always_comb begin
    pred_w = 64'(b_q) + 64'($signed(prod[65:16]));
    diff_w = 64'(rd_y) - pred_w;
    r_sat  = sat32(diff_w);
    g1_w   = 64'sd0 - (64'(r_q) <<< 1);
    g2_w   = 64'sd0 - (64'($signed(prod[65:16])) <<< 1);
    acc_b  = sat_add64(sum_b_q, g1_w);
    acc_m  = sat_add64(sum_m_q, g2_w);
  end

  // Scaled step from the high and low partial products, then the update
  always_comb begin
    t_w = (49'(hi_q) << 8) + 49'(prod[55:24]);
    if (|hi_q[55:40]) begin
      q_w = 41'h100_0000_0000;
    end else if (t_w > 49'h100_0000_0000) begin
      q_w = 41'h100_0000_0000;
    end else begin
      q_w = t_w[40:0];
    end
    step_sat = sat32(neg ? (64'sd0 - $signed(64'(q_w))) : $signed(64'(q_w)));
    par_w    = sel_q ? 64'(m_q) : 64'(b_q);
    upd_sat  = sat32(par_w - 64'(step_q));
  end

  // Sequencer, config registers and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      lr_q       <= LR_RESET;
      iter_cfg_q <= ITER_RESET;
      b0_q       <= B0_RESET;
      m0_q       <= M0_RESET;
      cnt_q      <= '0;
      idx_q      <= '0;
      iter_q     <= '0;
      ovf_q      <= 1'b0;
      done_q     <= 1'b0;
      sel_q      <= 1'b0;
      b_q        <= '0;
      m_q        <= '0;
      r_q        <= '0;
      step_q     <= '0;
      sum_b_q    <= '0;
      sum_m_q    <= '0;
      hi_q       <= '0;
    end else begin
      done_q <= 1'b0;

      // Config writes
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_LR:   lr_q       <= cfg_data_i[23:0];
          CFG_ITER: iter_cfg_q <= cfg_data_i[15:0];
          CFG_B0:   b0_q       <= cfg_data_i;
          CFG_M0:   m0_q       <= cfg_data_i;
        endcase
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            unique case (cmd_e'(cmd_i))
              CMD_CLEAR: begin
                cnt_q <= '0;
                ovf_q <= 1'b0;
              end
              CMD_LOAD: begin
                if (full) begin
                  ovf_q <= 1'b1;
                end else begin
                  cnt_q <= cnt_q + CW'(1);
                end
              end
              CMD_RUN: begin
                b_q     <= b0_q;
                m_q     <= m0_q;
                iter_q  <= iter_cfg_q;
                idx_q   <= '0;
                state_q <= ST_ITER;
              end
              CMD_NONE: ;
            endcase
          end
        end
        ST_ITER: begin
          if (iter_q == 16'd0) begin
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            sum_b_q <= '0;
            sum_m_q <= '0;
            idx_q   <= '0;
            state_q <= ST_PCHK;
          end
        end
        ST_PCHK: begin
          if (idx_q == cnt_q) begin
            sel_q   <= 1'b0;
            state_q <= ST_SHI;
          end else begin
            state_q <= ST_PMUL1;
          end
        end
        ST_PMUL1: state_q <= ST_PRES;
        ST_PRES: begin
          r_q     <= r_sat.val;
          ovf_q   <= ovf_q | r_sat.ovf;
          state_q <= ST_PMUL2;
        end
        ST_PMUL2: state_q <= ST_PACC;
        ST_PACC: begin
          sum_b_q <= acc_b.val;
          sum_m_q <= acc_m.val;
          ovf_q   <= ovf_q | acc_b.ovf | acc_m.ovf;
          idx_q   <= idx_q + CW'(1);
          state_q <= ST_PCHK;
        end
        ST_SHI: state_q <= ST_SLO;
        ST_SLO: begin
          hi_q    <= prod[55:0];
          state_q <= ST_STEP;
        end
        ST_STEP: begin
          step_q  <= step_sat.val;
          ovf_q   <= ovf_q | step_sat.ovf;
          state_q <= ST_UPD;
        end
        ST_UPD: begin
          ovf_q <= ovf_q | upd_sat.ovf;
          if (sel_q) begin
            m_q     <= upd_sat.val;
            iter_q  <= iter_q - 16'd1;
            state_q <= ST_ITER;
          end else begin
            b_q     <= upd_sat.val;
            sel_q   <= 1'b1;
            state_q <= ST_SHI;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Result ports hold the fitted parameters; the strobe marks the transaction
  assign done_o        = done_q;
  assign intercept_o   = b_q;
  assign slope_o       = m_q;
  assign points_used_o = 11'(cnt_q);
  assign saturated_o   = ovf_q;

  // Checks
  `ASSERT_IMPLIES(a_done_idle, clk_i, rst_ni, done_q, !busy)
  `ASSERT_NEXT(a_run_busy, clk_i, rst_ni, accept && (cmd_i == CMD_RUN), busy)
  `ASSERT_IMPLIES(a_idx_bound, clk_i, rst_ni, busy, idx_q <= cnt_q)
  `ASSERT_NEXT(a_flag_sticky, clk_i, rst_ni, busy && ovf_q, ovf_q)

endmodule

// ----- bench/tb.sv -----
// Self-checking testbench for the gradient descent line fit block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lrgd_pkg::*;

  localparam int unsigned MAX_POINTS  = 1024;
  localparam int unsigned QUIET_LIMIT = 2_000_000;
  localparam int unsigned COMMAND_TARGET = 420;

  localparam longint S32_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint S32_MIN = 64'shFFFF_FFFF_8000_0000;
  localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint S64_MIN = 64'sh8000_0000_0000_0000;
  localparam longint unsigned STEP_CAP = 64'h0000_0100_0000_0000;

  typedef struct {
    logic signed [31:0] intercept;
    logic signed [31:0] slope;
    logic [10:0]        points;
    logic               saturated;
  } fit_t;

  // Line fit predictor and result store
  class line_fit_scoreboard;
    logic [23:0]        rate;
    logic [15:0]        iters;
    logic signed [31:0] start_b;
    logic signed [31:0] start_m;
    longint             xs[MAX_POINTS];
    longint             ys[MAX_POINTS];
    int                 count;
    bit                 sat_flag;
    fit_t               pending_fits[$];
    int                 mismatches;
    int                 fits_checked;

    function new();
      rate    = LR_RESET;
      iters   = ITER_RESET;
      start_b = B0_RESET;
      start_m = M0_RESET;
      count   = 0;
      sat_flag = 1'b0;
      mismatches = 0;
      fits_checked = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [31:0] val);
      case (idx)
        CFG_LR:   rate = val[23:0];
        CFG_ITER: iters = val[15:0];
        CFG_B0:   start_b = val;
        CFG_M0:   start_m = val;
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > S32_MAX) begin
        sat_flag = 1'b1;
        return S32_MAX;
      end
      if (v < S32_MIN) begin
        sat_flag = 1'b1;
        return S32_MIN;
      end
      return v;
    endfunction

    function longint add_clamped(longint a, longint b);
      if (b > 0 && a > S64_MAX - b) begin
        sat_flag = 1'b1;
        return S64_MAX;
      end
      if (b < 0 && a < S64_MIN - b) begin
        sat_flag = 1'b1;
        return S64_MIN;
      end
      return a + b;
    endfunction

    // Scale a gradient sum by the rate, truncating toward zero
    function longint rate_step(longint s);
      bit neg;
      longint unsigned mag, hi, lo, q;
      neg = (s < 0);
      mag = neg ? longint'(-s) : s;
      hi = (mag >> 32) * rate;
      lo = (mag & 64'hFFFF_FFFF) * rate;
      if (hi >= STEP_CAP) begin
        q = STEP_CAP;
      end else begin
        q = (hi << 8) + (lo >> 24);
        if (q > STEP_CAP) q = STEP_CAP;
      end
      return clamp32(neg ? -longint'(q) : longint'(q));
    endfunction

    // Run the whole descent over the stored points
    function fit_t descend();
      longint b, m, sum_b, sum_m, r;
      fit_t f;
      b = start_b;
      m = start_m;
      for (int k = 0; k < iters; k++) begin
        sum_b = 0;
        sum_m = 0;
        for (int i = 0; i < count; i++) begin
          r = clamp32(ys[i] - (b + ((m * xs[i]) >>> 16)));
          sum_b = add_clamped(sum_b, -2 * r);
          sum_m = add_clamped(sum_m, -2 * ((r * xs[i]) >>> 16));
        end
        b = clamp32(b - rate_step(sum_b));
        m = clamp32(m - rate_step(sum_m));
      end
      f.intercept = b[31:0];
      f.slope     = m[31:0];
      f.points    = count[10:0];
      f.saturated = sat_flag;
      return f;
    endfunction

    // Note an accepted command transaction
    function void take_command(cmd_e c, logic signed [31:0] xv, logic signed [31:0] yv);
      case (c)
        CMD_CLEAR: begin
          count = 0;
          sat_flag = 1'b0;
        end
        CMD_LOAD: begin
          if (count >= MAX_POINTS) begin
            sat_flag = 1'b1;
          end else begin
            xs[count] = xv;
            ys[count] = yv;
            count++;
          end
        end
        CMD_RUN: pending_fits.insert(pending_fits.size(), descend());
        default: ;
      endcase
    endfunction

    function void compare(string what, logic signed [63:0] want, logic signed [63:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      end
    endfunction

    // Check one fit against the oldest pending one
    function void check_fit(logic signed [31:0] b, logic signed [31:0] m,
                            logic [10:0] n, logic s);
      fit_t e;
      if (pending_fits.size() == 0) begin
        mismatches++;
        $display("%0t: fit with none pending: expected nothing, got intercept %0d slope %0d",
                 $time, b, m);
        return;
      end
      e = pending_fits.pop_front();
      fits_checked++;
      compare("intercept", e.intercept, b);
      compare("slope", e.slope, m);
      compare("points_used", e.points, n);
      compare("saturated", e.saturated, s);
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [1:0]         cmd_i;
  logic signed [31:0] x_i;
  logic signed [31:0] y_i;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i;
  logic [31:0]        cfg_data_i;
  logic               done_o;
  logic signed [31:0] intercept_o;
  logic signed [31:0] slope_o;
  logic [10:0]        points_used_o;
  logic               saturated_o;

  line_fit_scoreboard sb = new();
  int commands_done = 0;
  int reg_writes = 0;
  int burst_left = 0;
  int quiet_cycles = 0;

  linear_regression_gradient_descent_top #(
    .MAX_POINTS(MAX_POINTS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .cmd_i        (cmd_i),
    .x_i          (x_i),
    .y_i          (y_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .done_o       (done_o),
    .intercept_o  (intercept_o),
    .slope_o      (slope_o),
    .points_used_o(points_used_o),
    .saturated_o  (saturated_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Check each fit in the cycle its strobe is up
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_fit(intercept_o, slope_o, points_used_o, saturated_o);
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Watchdog expired at %0t after %0d quiet cycles", $time, quiet_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic int near(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic [31:0] pick_rate();
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return 32'h00FF_FFFF;
      2: return $urandom_range(1, 65535);
      default: return $urandom & 32'h00FF_FFFF;
    endcase
  endfunction

  function automatic logic [31:0] pick_wide();
    case ($urandom_range(0, 3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Drop start for a random gap between bursts
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 5);
      @(negedge clk_i);
      start <= 1'b0;
      cmd_i <= $urandom;
      x_i <= $urandom;
      y_i <= $urandom;
      repeat (gap - 1) @(negedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 4);
    end
  endtask

  // Present one command and hold it until the block takes it
  task automatic issue(cmd_e c, logic signed [31:0] xv, logic signed [31:0] yv);
    @(negedge clk_i);
    start <= 1'b1;
    cmd_i <= c;
    x_i <= xv;
    y_i <= yv;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.take_command(c, xv, yv);
    if (c != CMD_NONE) commands_done++;
    pace();
  endtask

  // Drain all pending fits so the block is idle
  task automatic quiesce();
    @(negedge clk_i);
    start <= 1'b0;
    while (sb.pending_fits.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(idx, val);
    reg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One phase: new settings, a point set, then one or more runs
  task automatic random_phase();
    logic signed [31:0] true_b, true_m, xv;
    longint yl;
    int n_pts;
    bit tidy;
    tidy = ($urandom_range(0, 2) != 0);
    quiesce();
    if (tidy) write_reg(CFG_LR, $urandom_range(256, 4096));
    else if ($urandom_range(0, 3) != 0) write_reg(CFG_LR, pick_rate());
    if ($urandom_range(0, 3) != 0)
      write_reg(CFG_ITER, ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6));
    if ($urandom_range(0, 2) != 0) write_reg(CFG_B0, tidy ? near(1 << 19) : pick_wide());
    if ($urandom_range(0, 2) != 0) write_reg(CFG_M0, tidy ? near(1 << 18) : pick_wide());
    if ($urandom_range(0, 3) != 0) issue(CMD_CLEAR, $urandom, $urandom);
    n_pts = $urandom_range(0, 20);
    true_b = near(1 << 18);
    true_m = near(1 << 18);
    for (int i = 0; i < n_pts; i++) begin
      if ($urandom_range(0, 9) == 0) issue(CMD_NONE, $urandom, $urandom);
      if ($urandom_range(0, 14) == 0) issue(CMD_RUN, $urandom, $urandom);
      if (tidy) begin
        // Points near a known line, so the fit stays in range
        xv = near(1 << 19);
        yl = true_b + ((longint'(true_m) * longint'(xv)) >>> 16) + near(1 << 14);
        issue(CMD_LOAD, xv, yl[31:0]);
      end else if ($urandom_range(0, 1) == 0) begin
        issue(CMD_LOAD, $urandom, $urandom);
      end else begin
        issue(CMD_LOAD, near(1 << 22), near(1 << 22));
      end
    end
    issue(CMD_RUN, $urandom, $urandom);
    if ($urandom_range(0, 3) == 0) issue(CMD_RUN, $urandom, $urandom);
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    cmd_i = CMD_CLEAR;
    x_i = '0;
    y_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_LR;
    cfg_data_i = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings on an empty store give back the starting values
    issue(CMD_RUN, 32'sh0, 32'sh0);
    issue(CMD_NONE, 32'sh7FFF_FFFF, 32'sh8000_0000);

    // Extreme points and settings, the flag stays set across runs
    quiesce();
    write_reg(CFG_LR, 32'h00FF_FFFF);
    write_reg(CFG_ITER, 32'd3);
    write_reg(CFG_B0, 32'h7FFF_FFFF);
    write_reg(CFG_M0, 32'h8000_0000);
    issue(CMD_LOAD, 32'sh0, 32'sh0);
    issue(CMD_LOAD, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    issue(CMD_LOAD, 32'sh8000_0000, 32'sh8000_0000);
    issue(CMD_LOAD, 32'sh8000_0000, 32'sh7FFF_FFFF);
    issue(CMD_LOAD, 32'sh0001_0000, 32'sh0002_0000);
    issue(CMD_RUN, 32'sh0, 32'sh0);
    issue(CMD_RUN, 32'shFFFF_FFFF, 32'shFFFF_FFFF);
    issue(CMD_NONE, 32'sh0, 32'sh0);
    issue(CMD_CLEAR, 32'sh0, 32'sh0);
    issue(CMD_RUN, 32'sh0, 32'sh0);

    // Zero iterations leave the starting values
    quiesce();
    write_reg(CFG_ITER, 32'd0);
    write_reg(CFG_LR, 32'd0);
    write_reg(CFG_B0, 32'h8000_0000);
    write_reg(CFG_M0, 32'h7FFF_FFFF);
    issue(CMD_LOAD, 32'sh0003_0000, 32'shFFFE_0000);
    issue(CMD_LOAD, 32'shFFFF_0000, 32'sh0001_8000);
    issue(CMD_RUN, 32'sh0, 32'sh0);

    // Longest iteration count on an empty store
    quiesce();
    write_reg(CFG_ITER, 32'd65535);
    write_reg(CFG_LR, 32'd1);
    write_reg(CFG_B0, $urandom);
    write_reg(CFG_M0, $urandom);
    issue(CMD_CLEAR, 32'sh0, 32'sh0);
    issue(CMD_RUN, 32'sh0, 32'sh0);

    // Back to a short iteration count before the point sets grow
    quiesce();
    write_reg(CFG_ITER, 32'd3);

    while (commands_done < COMMAND_TARGET) random_phase();

    // Fill the store, overrun it, and fit over every entry
    quiesce();
    write_reg(CFG_ITER, 32'd1);
    write_reg(CFG_LR, $urandom_range(1, 64));
    issue(CMD_CLEAR, 32'sh0, 32'sh0);
    for (int i = 0; i < MAX_POINTS + 3; i++) issue(CMD_LOAD, near(1 << 19), near(1 << 19));
    issue(CMD_RUN, 32'sh0, 32'sh0);
    quiesce();
    write_reg(CFG_ITER, 32'd2);
    issue(CMD_RUN, 32'sh0, 32'sh0);

    quiesce();
    repeat (20) @(posedge clk_i);
    $display("Ran %0d commands with %0d register writes; %0d fits compared field by field.",
             commands_done, reg_writes, sb.fits_checked);
    $display("Fits left unmatched: %0d, mismatches: %0d.", sb.pending_fits.size(),
             sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_fits.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/lrgd_pkg.sv
rtl/core/lrgd_mul.sv
rtl/core/lrgd_store.sv
rtl/core/linear_regression_gradient_descent_top.sv
bench/tb.sv
